/* src/flha_pkg.sv */
// ----------------------------------------------------------------------------
// flha_pkg: shared types and codes for the free-list heap allocator
// Function codes, result status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package flha_pkg;

  typedef enum logic [1:0] {
    FUNC_MALLOC = 2'd0,
    FUNC_CALLOC = 2'd1,
    FUNC_FREE   = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_NO_SPACE = 2'd1,
    STAT_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL,
    ST_PCHK,
    ST_DPRE,
    ST_DIV,
    ST_A_INIT,
    ST_A_P,
    ST_A_CHK,
    ST_A_SPLIT,
    ST_GROW,
    ST_R_INIT,
    ST_R_WALK,
    ST_R_RDB,
    ST_R_RDC,
    ST_R_UPD,
    ST_DONE
  } state_t;

endpackage

/* src/free_list_heap_allocator.sv */
// ----------------------------------------------------------------------------
// free_list_heap_allocator
// Next-fit circular free-list allocator; headers held in two on-chip RAMs.
// ----------------------------------------------------------------------------
// Usage: one request beat on the in_ channel (func selects malloc, calloc or
// free), one result beat on the out_ channel (status, granted_addr) for every
// request. Requests are taken one at a time; in_stall is high while a
// request is being worked on.
// Sequence: a malloc turns bytes into units (reciprocal multiply), starts
// the walk, visits one free-list block per cycle (one read of the link and
// size RAMs each), splits the block when it is larger than the request and
// loads the result. A heap grow adds header updates, the release walk at
// one block per cycle, and a restart of the search. A free is the release
// walk plus header updates. Calloc first forms the product. Both walks
// grow with fragmentation.
// After rst_n the sentinel header (unit 0) links to itself with size zero,
// the roving pointer is 0 and the break sits at unit 1; no clearing pass.
// The result sits in an output register; a new request is taken while it
// waits, but the next result is held back until out_stall drops.
// ----------------------------------------------------------------------------
module free_list_heap_allocator #(
  parameter int HEAP_UNITS = 4096,
  parameter int MIN_GROW   = 1024,
  parameter int UNIT_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_byte_count,
  input  logic [31:0] in_elem_count,
  input  logic [31:0] in_elem_bytes,
  input  logic [11:0] in_payload_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [11:0] out_granted_addr
);

  localparam int AW  = $clog2(HEAP_UNITS);
  localparam int SW  = AW + 1;
  localparam int NUW = SW + 1;
  localparam int MGW = $clog2(MIN_GROW + 1);
  localparam int GW  = ((NUW > MGW) ? NUW : MGW) + 1;
  localparam longint LIMIT   = 4 * longint'(HEAP_UNITS) + 8;
  localparam int     CW      = $clog2(LIMIT + 1);
  localparam longint BIG_BYTES = longint'(UNIT_BYTES) * longint'(HEAP_UNITS);
  localparam int     NW      = $clog2(BIG_BYTES + UNIT_BYTES);
  // floor(num / UNIT_BYTES) = (num * RECIP) >> DSH, exact for num < 2**NW
  localparam int     DSH     = NW + $clog2(UNIT_BYTES) + 1;
  localparam int     RCW     = NW + 2;
  localparam longint RECIP   = ((longint'(1) << DSH) + longint'(UNIT_BYTES) - 1) /
                               longint'(UNIT_BYTES);

  // header RAMs; unit 0 (sentinel) lives in flops so that reset covers it
  logic [AW-1:0] link_mem [HEAP_UNITS];
  logic [SW-1:0] size_mem [HEAP_UNITS];
  logic [AW-1:0] link0_r, link_rd_r, lra, lra_r, lwa, lwd;
  logic [SW-1:0] size0_r, size_rd_r, swd;
  logic [AW-1:0] sra, sra_r, swa;
  logic          lwe, swe;
  logic [AW-1:0] link_q;
  logic [SW-1:0] size_q;

  flha_pkg::state_t state_r, state_nxt;

  logic [31:0]    op_a_r, op_a_nxt, op_b_r, op_b_nxt;
  logic [63:0]    prod_r, prod_nxt;
  logic [NW-1:0]  num_r, num_nxt;
  logic [NUW-1:0] nunits_r, nunits_nxt;
  logic [AW-1:0]  rover_r, rover_nxt;
  logic [SW-1:0]  hb_r, hb_nxt;
  logic [AW-1:0]  prev_r, prev_nxt, p_r, p_nxt, nx_r, nx_nxt, hdr_r, hdr_nxt;
  logic [AW-1:0]  lnx_r, lnx_nxt, lh2_r, lh2_nxt;
  logic [SW-1:0]  sh_r, sh_nxt, sh2_r, sh2_nxt;
  logic [SW:0]    split_r, split_nxt;
  logic [CW-1:0]  asteps_r, asteps_nxt, rsteps_r, rsteps_nxt;
  logic           from_grow_r, from_grow_nxt;
  logic [1:0]     res_stat_r, res_stat_nxt;
  logic [11:0]    res_addr_r, res_addr_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [1:0]     out_status_r, out_status_nxt;
  logic [11:0]    out_addr_r, out_addr_nxt;

  // walk and update terms
  logic           r_found, r_limit, a_limit, a_fit, a_exact, grow_fail;
  logic [NW+RCW-1:0] div_prod;
  logic [SW-1:0]  a_rest;
  logic [SW:0]    hdr_end, p_end, a_split;
  logic [GW-1:0]  grow_nu;
  logic [31:0]    addr_ext;

  assign link_q = (lra_r == '0) ? link0_r : link_rd_r;
  assign size_q = (sra_r == '0) ? size0_r : size_rd_r;

  always_ff @(posedge clk) begin
    link_rd_r <= link_mem[lra];
    size_rd_r <= size_mem[sra];
    lra_r     <= lra;
    sra_r     <= sra;
    if (lwe && lwa != '0) begin
      link_mem[lwa] <= lwd;
    end
    if (swe && swa != '0) begin
      size_mem[swa] <= swd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link0_r <= '0;
      size0_r <= '0;
    end else begin
      if (lwe && lwa == '0) begin
        link0_r <= lwd;
      end
      if (swe && swa == '0) begin
        size0_r <= swd;
      end
    end
  end

  // combinational terms
  assign r_found  = ((hdr_r > p_r) && (hdr_r < link_q)) ||
                    ((p_r >= link_q) && ((hdr_r > p_r) || (hdr_r < link_q)));
  assign r_limit  = (CW'(rsteps_r) == CW'(LIMIT));
  assign a_limit  = (CW'(asteps_r) == CW'(LIMIT));
  assign a_fit    = (NUW'(size_q) >= nunits_r);
  assign a_exact  = (NUW'(size_q) == nunits_r);
  assign a_rest   = size_q - SW'(nunits_r);
  assign a_split  = (SW + 1)'(p_r) + (SW + 1)'(a_rest);
  assign hdr_end  = (SW + 1)'(hdr_r) + (SW + 1)'(sh_r);
  assign p_end    = (SW + 1)'(p_r) + (SW + 1)'(size_q);
  assign div_prod = (NW + RCW)'(num_r) * (NW + RCW)'(RECIP);
  assign grow_nu  = (GW'(nunits_r) > GW'(MIN_GROW)) ? GW'(nunits_r) : GW'(MIN_GROW);
  assign grow_fail = (GW'(hb_r) + grow_nu) > GW'(HEAP_UNITS);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      flha_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_func)
            flha_pkg::FUNC_MALLOC: state_nxt = flha_pkg::ST_DPRE;
            flha_pkg::FUNC_CALLOC: state_nxt = flha_pkg::ST_MUL;
            flha_pkg::FUNC_FREE: begin
              if (in_payload_addr != '0 && 32'(in_payload_addr) < 32'(hb_r)) begin
                state_nxt = flha_pkg::ST_R_INIT;
              end else begin
                state_nxt = flha_pkg::ST_DONE;
              end
            end
            default: state_nxt = flha_pkg::ST_DONE;
          endcase
        end
      end
      flha_pkg::ST_MUL:  state_nxt = flha_pkg::ST_PCHK;
      flha_pkg::ST_PCHK: begin
        state_nxt = (prod_r[63:32] != '0) ? flha_pkg::ST_DONE : flha_pkg::ST_DPRE;
      end
      flha_pkg::ST_DPRE: begin
        state_nxt = (64'(op_a_r) >= 64'(BIG_BYTES)) ? flha_pkg::ST_A_INIT : flha_pkg::ST_DIV;
      end
      flha_pkg::ST_DIV:    state_nxt = flha_pkg::ST_A_INIT;
      flha_pkg::ST_A_INIT: state_nxt = flha_pkg::ST_A_P;
      flha_pkg::ST_A_P:    state_nxt = flha_pkg::ST_A_CHK;
      flha_pkg::ST_A_CHK: begin
        if (a_limit) begin
          state_nxt = flha_pkg::ST_DONE;
        end else if (a_fit) begin
          state_nxt = a_exact ? flha_pkg::ST_DONE : flha_pkg::ST_A_SPLIT;
        end else if (p_r == rover_r) begin
          state_nxt = flha_pkg::ST_GROW;
        end
      end
      flha_pkg::ST_A_SPLIT: state_nxt = flha_pkg::ST_DONE;
      flha_pkg::ST_GROW: begin
        state_nxt = grow_fail ? flha_pkg::ST_DONE : flha_pkg::ST_R_INIT;
      end
      flha_pkg::ST_R_INIT: state_nxt = flha_pkg::ST_R_WALK;
      flha_pkg::ST_R_WALK: begin
        if (r_limit) begin
          state_nxt = from_grow_r ? flha_pkg::ST_A_INIT : flha_pkg::ST_DONE;
        end else if (r_found) begin
          state_nxt = flha_pkg::ST_R_RDB;
        end
      end
      flha_pkg::ST_R_RDB: state_nxt = flha_pkg::ST_R_RDC;
      flha_pkg::ST_R_RDC: state_nxt = flha_pkg::ST_R_UPD;
      flha_pkg::ST_R_UPD: begin
        state_nxt = from_grow_r ? flha_pkg::ST_A_INIT : flha_pkg::ST_DONE;
      end
      flha_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = flha_pkg::ST_IDLE;
      end
      default: state_nxt = flha_pkg::ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    op_a_nxt      = op_a_r;
    op_b_nxt      = op_b_r;
    prod_nxt      = prod_r;
    num_nxt       = num_r;
    nunits_nxt    = nunits_r;
    rover_nxt     = rover_r;
    hb_nxt        = hb_r;
    prev_nxt      = prev_r;
    p_nxt         = p_r;
    nx_nxt        = nx_r;
    hdr_nxt       = hdr_r;
    lnx_nxt       = lnx_r;
    lh2_nxt       = lh2_r;
    sh_nxt        = sh_r;
    sh2_nxt       = sh2_r;
    split_nxt     = split_r;
    asteps_nxt    = asteps_r;
    rsteps_nxt    = rsteps_r;
    from_grow_nxt = from_grow_r;
    res_stat_nxt  = res_stat_r;
    res_addr_nxt  = res_addr_r;
    out_valid_nxt = out_valid_r;
    out_status_nxt = out_status_r;
    out_addr_nxt  = out_addr_r;
    lra = lra_r;
    sra = sra_r;
    lwe = 1'b0;
    lwa = '0;
    lwd = '0;
    swe = 1'b0;
    swa = '0;
    swd = '0;
    addr_ext = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      flha_pkg::ST_IDLE: begin
        if (in_valid) begin
          res_stat_nxt = flha_pkg::STAT_DONE;
          res_addr_nxt = '0;
          if (in_func == flha_pkg::FUNC_CALLOC) begin
            op_a_nxt = in_elem_count;
            op_b_nxt = in_elem_bytes;
          end else begin
            op_a_nxt = in_byte_count;
          end
          hdr_nxt       = AW'(32'(in_payload_addr) - 32'd1);
          from_grow_nxt = 1'b0;
        end
      end
      flha_pkg::ST_MUL: prod_nxt = 64'(op_a_r) * 64'(op_b_r);
      flha_pkg::ST_PCHK: begin
        op_a_nxt = prod_r[31:0];
        if (prod_r[63:32] != '0) res_stat_nxt = flha_pkg::STAT_OVERFLOW;
      end
      flha_pkg::ST_DPRE: begin
        asteps_nxt = '0;
        num_nxt    = NW'(64'(op_a_r) + 64'(UNIT_BYTES - 1));
        nunits_nxt = NUW'(HEAP_UNITS + 1);
      end
      flha_pkg::ST_DIV: begin
        // units = rounded-up quotient plus the header unit
        nunits_nxt = NUW'(div_prod[NW+RCW-1:DSH]) + NUW'(1);
      end
      flha_pkg::ST_A_INIT: begin
        prev_nxt = rover_r;
        lra      = rover_r;
      end
      flha_pkg::ST_A_P: begin
        p_nxt = link_q;
        lra   = link_q;
        sra   = link_q;
      end
      flha_pkg::ST_A_CHK: begin
        if (a_limit) begin
          res_stat_nxt = flha_pkg::STAT_NO_SPACE;
        end else if (a_fit) begin
          rover_nxt = prev_r;
          if (a_exact) begin
            lwe = 1'b1;
            lwa = prev_r;
            lwd = link_q;
            addr_ext = 32'(p_r) + 32'd1;
            res_addr_nxt = addr_ext[11:0];
          end else begin
            // carve the request from the tail of the block
            swe = 1'b1;
            swa = p_r;
            swd = a_rest;
            split_nxt = a_split;
          end
        end else if (p_r == rover_r) begin
          asteps_nxt = asteps_r + 1'b1;
        end else begin
          asteps_nxt = asteps_r + 1'b1;
          prev_nxt   = p_r;
          p_nxt      = link_q;
          lra        = link_q;
          sra        = link_q;
        end
      end
      flha_pkg::ST_A_SPLIT: begin
        if (split_r < (SW + 1)'(HEAP_UNITS)) begin
          swe = 1'b1;
          swa = AW'(split_r);
          swd = SW'(nunits_r);
        end
        addr_ext = 32'(split_r) + 32'd1;
        res_addr_nxt = addr_ext[11:0];
      end
      flha_pkg::ST_GROW: begin
        if (grow_fail) begin
          res_stat_nxt = flha_pkg::STAT_NO_SPACE;
        end else begin
          swe = 1'b1;
          swa = AW'(hb_r);
          swd = SW'(grow_nu);
          hdr_nxt = AW'(hb_r);
          hb_nxt  = SW'(GW'(hb_r) + grow_nu);
          from_grow_nxt = 1'b1;
        end
      end
      flha_pkg::ST_R_INIT: begin
        p_nxt      = rover_r;
        rsteps_nxt = '0;
        lra        = rover_r;
      end
      flha_pkg::ST_R_WALK: begin
        if (!r_limit) begin
          if (r_found) begin
            nx_nxt = link_q;
            sra    = hdr_r;
            lra    = link_q;
          end else begin
            p_nxt      = link_q;
            rsteps_nxt = rsteps_r + 1'b1;
            lra        = link_q;
          end
        end
      end
      flha_pkg::ST_R_RDB: begin
        sh_nxt  = size_q;
        lnx_nxt = link_q;
        sra     = nx_r;
      end
      flha_pkg::ST_R_RDC: begin
        // merge with the upper neighbour
        lwe = 1'b1;
        lwa = hdr_r;
        if (hdr_end == (SW + 1)'(nx_r)) begin
          sh2_nxt = sh_r + size_q;
          lh2_nxt = lnx_r;
          swe = 1'b1;
          swa = hdr_r;
          swd = sh_r + size_q;
          lwd = lnx_r;
        end else begin
          sh2_nxt = sh_r;
          lh2_nxt = nx_r;
          lwd = nx_r;
        end
        sra = p_r;
      end
      flha_pkg::ST_R_UPD: begin
        // merge with the lower neighbour
        lwe = 1'b1;
        lwa = p_r;
        if (p_end == (SW + 1)'(hdr_r)) begin
          swe = 1'b1;
          swa = p_r;
          swd = size_q + sh2_r;
          lwd = lh2_r;
        end else begin
          lwd = hdr_r;
        end
        rover_nxt = p_r;
      end
      flha_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_stat_r;
          out_addr_nxt   = res_addr_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= flha_pkg::ST_IDLE;
      rover_r     <= '0;
      hb_r        <= SW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rover_r     <= rover_nxt;
      hb_r        <= hb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_a_r       <= op_a_nxt;
    op_b_r       <= op_b_nxt;
    prod_r       <= prod_nxt;
    num_r        <= num_nxt;
    nunits_r     <= nunits_nxt;
    prev_r       <= prev_nxt;
    p_r          <= p_nxt;
    nx_r         <= nx_nxt;
    hdr_r        <= hdr_nxt;
    lnx_r        <= lnx_nxt;
    lh2_r        <= lh2_nxt;
    sh_r         <= sh_nxt;
    sh2_r        <= sh2_nxt;
    split_r      <= split_nxt;
    asteps_r     <= asteps_nxt;
    rsteps_r     <= rsteps_nxt;
    from_grow_r  <= from_grow_nxt;
    res_stat_r   <= res_stat_nxt;
    res_addr_r   <= res_addr_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  assign in_stall         = (state_r != flha_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_granted_addr = out_addr_r;

endmodule
